// ===== design/two_sum_pair_finder_core_assert.svh =====
// Assertion macros for the two-sum pair finder RTL.
// Included by tsp_dp, which carries concurrent checks; no other dependencies.
`ifndef TWO_SUM_PAIR_FINDER_CORE_ASSERT_SVH
`define TWO_SUM_PAIR_FINDER_CORE_ASSERT_SVH

// same-cycle implication
`define TSP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsp assertion failed");

// next-cycle implication
`define TSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsp assertion failed");

`endif

// ===== design/tsp_pkg.sv =====
// Shared types and constants for the two-sum pair finder.
// No dependencies.
package tsp_pkg;

   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      TSP_IDLE,
      TSP_SCAN,
      TSP_FINISH
   } tsp_state_type;

   typedef enum logic [1:0] {
      ST_SEARCH  = 2'd0,
      ST_FOUND   = 2'd1,
      ST_IGNORED = 2'd2,
      ST_END     = 2'd3
   } tsp_status_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } tsp_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } tsp_sts_type;

endpackage

// ===== design/tsp_ctrl.sv =====
// Request sequencer of the two-sum pair finder: accept, scan, commit.
// Depends on tsp_pkg.
module tsp_ctrl
   import tsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  tsp_sts_type sts,
   output tsp_cmd_type cmd
);

   tsp_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TSP_IDLE: begin
            if (req_valid) state_in = TSP_SCAN;
         end
         TSP_SCAN: begin
            if (sts.scan_done) state_in = TSP_FINISH;
         end
         TSP_FINISH: begin
            if (sts.out_free) state_in = TSP_IDLE;
         end
         default: state_in = TSP_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         TSP_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         TSP_SCAN: begin
            cmd.scan = 1'b1;
         end
         TSP_FINISH: begin
            cmd.commit = sts.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TSP_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/tsp_dp.sv =====
// Datapath of the two-sum pair finder: target register, value store,
// sequential lookup, insert and result register. Depends on tsp_pkg and the assert header.
`include "two_sum_pair_finder_core_assert.svh"
module tsp_dp
   import tsp_pkg::*;
#(
   parameter int SET_CAPACITY = 256
)(
   input  logic                     clock,
   input  logic                     reset,
   input  tsp_cmd_type              cmd,
   output tsp_sts_type              sts,
   input  logic                     csr_write_enable,
   input  logic signed [DATA_W-1:0] csr_write_data,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     req_first_item,
   input  logic                     req_last_item,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_partner_value,
   output logic signed [DATA_W-1:0] rsp_current_value,
   output logic                     rsp_overflowed
);

   localparam int AW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
   localparam int CW = $clog2(SET_CAPACITY + 1);
   localparam logic [CW-1:0] CAP = CW'(SET_CAPACITY);

   logic [DATA_W-1:0] mem_ff [SET_CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   logic [DATA_W-1:0] target_ff, target_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              pair_done_ff, pair_done_in;
   logic              ovf_ff, ovf_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              diff_hit_ff, diff_hit_in;
   logic              val_hit_ff, val_hit_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [DATA_W-1:0] val_ff, diff_ff;
   logic              in_range_ff, last_ff;
   tsp_status_type    out_status_ff, out_status_in;
   logic [DATA_W-1:0] out_partner_ff, out_partner_in;
   logic [DATA_W-1:0] out_current_ff;
   logic              out_ovf_ff;

   logic [DATA_W:0]   diff_wide;
   logic              issue, full, insert, do_write;

   assign diff_wide = {target_ff[DATA_W-1], target_ff} - {req_value[DATA_W-1], req_value};
   assign issue     = cmd.scan && (idx_ff < count_ff) && !diff_hit_ff && !pair_done_ff;
   assign full      = (count_ff == CAP);
   assign insert    = cmd.commit && !pair_done_ff && !diff_hit_ff && !val_hit_ff;
   assign do_write  = insert && !full;

   assign sts.scan_done = pair_done_ff || diff_hit_ff || ((idx_ff == count_ff) && !rd_pend_ff);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      target_in      = csr_write_enable ? csr_write_data : target_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      pair_done_in   = pair_done_ff;
      ovf_in         = ovf_ff;
      rd_pend_in     = issue;
      diff_hit_in    = diff_hit_ff;
      val_hit_in     = val_hit_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      out_status_in  = last_ff ? ST_END : ST_SEARCH;
      out_partner_in = '0;

      if (cmd.load) begin
         idx_in      = '0;
         diff_hit_in = 1'b0;
         val_hit_in  = 1'b0;
         if (req_first_item) begin
            count_in     = '0;
            pair_done_in = 1'b0;
         end
      end

      if (issue) idx_in = idx_ff + 1'b1;

      if (rd_pend_ff) begin
         if (in_range_ff && (rd_data_ff == diff_ff)) diff_hit_in = 1'b1;
         if (rd_data_ff == val_ff) val_hit_in = 1'b1;
      end

      if (pair_done_ff) begin
         out_status_in = ST_IGNORED;
      end else if (diff_hit_ff) begin
         out_status_in  = ST_FOUND;
         out_partner_in = diff_ff;
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         if (!pair_done_ff && diff_hit_ff) pair_done_in = 1'b1;
         if (do_write) count_in = count_ff + 1'b1;
         if (insert && full) ovf_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         pair_done_ff <= 1'b0;
         ovf_ff       <= 1'b0;
         rd_pend_ff   <= 1'b0;
         diff_hit_ff  <= 1'b0;
         val_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         pair_done_ff <= pair_done_in;
         ovf_ff       <= ovf_in;
         rd_pend_ff   <= rd_pend_in;
         diff_hit_ff  <= diff_hit_in;
         val_hit_ff   <= val_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         val_ff      <= req_value;
         diff_ff     <= diff_wide[DATA_W-1:0];
         in_range_ff <= (diff_wide[DATA_W] == diff_wide[DATA_W-1]);
         last_ff     <= req_last_item;
      end
      if (cmd.commit) begin
         out_status_ff  <= out_status_in;
         out_partner_ff <= out_partner_in;
         out_current_ff <= val_ff;
         out_ovf_ff     <= ovf_in;
      end
   end

   // value store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (do_write) mem_ff[count_ff[AW-1:0]] <= val_ff;
      if (issue) rd_data_ff <= mem_ff[idx_ff[AW-1:0]];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_partner_value = out_partner_ff;
   assign rsp_current_value = out_current_ff;
   assign rsp_overflowed    = out_ovf_ff;

   `TSP_ASSERT_IMPL(a_count_cap, clock, reset, 1'b1, count_ff <= CAP)
   `TSP_ASSERT_IMPL(a_idx_le_count, clock, reset, cmd.scan, idx_ff <= count_ff)
   `TSP_ASSERT_IMPL(a_commit_free, clock, reset, cmd.commit, !rsp_valid_ff || !rsp_stall)
   `TSP_ASSERT_NEXT(a_found_no_ins, clock, reset, cmd.commit && diff_hit_ff, $stable(count_ff))

endmodule

// ===== design/two_sum_pair_finder_core.sv =====
// Top level of the two-sum pair finder: sequencer plus datapath.
// Depends on tsp_pkg, tsp_ctrl and tsp_dp.
//
//   port group   direction   handshake            payload
//   req_*        in          req_valid/req_stall  value, first_item, last_item
//   rsp_*        out         rsp_valid/rsp_stall  status, partner_value,
//                                                 current_value, overflowed
//   csr_*        in          csr_write_enable     write_data (target sum)
//
// Each request looks up the values held for the current array, count being
// their number (0 to SET_CAPACITY): the store is scanned one entry per cycle
// through its single registered read port, and a hit ends the scan early.
// Items after a pair skip the scan.
// Reset clears the set count, pair and overflow flags and the target; no
// clearing pass. A stalled result is held while the next request is scanned.
module two_sum_pair_finder_core
   import tsp_pkg::*;
#(
   parameter int SET_CAPACITY = 256
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic signed [DATA_W-1:0] csr_write_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     req_first_item,
   input  logic                     req_last_item,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_partner_value,
   output logic signed [DATA_W-1:0] rsp_current_value,
   output logic                     rsp_overflowed
);

   tsp_cmd_type cmd;
   tsp_sts_type sts;

   tsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tsp_dp #(
      .SET_CAPACITY (SET_CAPACITY)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_value         (req_value),
      .req_first_item    (req_first_item),
      .req_last_item     (req_last_item),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_partner_value (rsp_partner_value),
      .rsp_current_value (rsp_current_value),
      .rsp_overflowed    (rsp_overflowed)
   );

endmodule

// ===== dv/tb_top.sv =====
// Testbench for two_sum_pair_finder_core: directed and random arrays of values,
// with a pair-search tracker that predicts every response and checks it.
// Depends on tsp_pkg and the two_sum_pair_finder_core RTL.
module tb_top;
   import tsp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SET_CAPACITY = 256;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 300;
   localparam int MAX_REPORTS = 30;
   localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      bit first_item;
      bit last_item;
   } value_request_type;

   typedef struct {
      tsp_status_type status;
      logic signed [DATA_W-1:0] partner_value;
      logic signed [DATA_W-1:0] current_value;
      logic overflowed;
   } pair_outcome_type;

   class two_sum_tracker;
      logic signed [DATA_W-1:0] target_sum;
      logic signed [DATA_W-1:0] held_values[$];
      bit pair_seen;
      bit overflow_seen;
      pair_outcome_type expected_outcomes[$];
      int error_count;
      int request_count;
      int target_writes;
      int found_count;
      int end_count;
      int ignored_count;

      function new();
         target_sum = '0;
         pair_seen = 1'b0;
         overflow_seen = 1'b0;
      endfunction

      function void set_target(logic signed [DATA_W-1:0] target);
         target_sum = target;
         target_writes++;
      endfunction

      function bit holds(logic signed [DATA_W-1:0] value);
         foreach (held_values[i])
            if (held_values[i] == value) return 1'b1;
         return 1'b0;
      endfunction

      function int outstanding();
         return expected_outcomes.size();
      endfunction

      // prediction for one accepted request
      function void note_value(logic signed [DATA_W-1:0] value, bit first_item, bit last_item);
         pair_outcome_type want;
         longint difference;
         logic signed [DATA_W-1:0] wanted;
         request_count++;
         want.partner_value = '0;
         want.current_value = value;
         if (first_item) begin
            held_values.delete();
            pair_seen = 1'b0;
         end
         if (pair_seen) begin
            want.status = ST_IGNORED;
         end else begin
            // 33-bit difference; out of 32-bit range never matches
            difference = longint'(target_sum) - longint'(value);
            wanted = difference[DATA_W-1:0];
            if (longint'(wanted) == difference && holds(wanted)) begin
               want.status = ST_FOUND;
               want.partner_value = wanted;
               pair_seen = 1'b1;
            end else begin
               if (!holds(value)) begin
                  if (held_values.size() < SET_CAPACITY)
                     held_values.insert(held_values.size(), value);
                  else overflow_seen = 1'b1;
               end
               want.status = last_item ? ST_END : ST_SEARCH;
            end
         end
         want.overflowed = overflow_seen;
         expected_outcomes.insert(expected_outcomes.size(), want);
      endfunction

      function void compare_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
         if (got !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, field, want, got);
         end
      endfunction

      function void check_outcome(logic [1:0] status, logic [DATA_W-1:0] partner_value,
                                  logic [DATA_W-1:0] current_value, logic overflowed);
         pair_outcome_type want;
         if (expected_outcomes.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: response with no request pending, expected none, got status %0d",
                        $time, status);
            return;
         end
         want = expected_outcomes.pop_front();
         case (want.status)
            ST_FOUND: found_count++;
            ST_END: end_count++;
            ST_IGNORED: ignored_count++;
            default: ;
         endcase
         compare_field("status", 32'(want.status), 32'(status));
         compare_field("partner_value", want.partner_value, partner_value);
         compare_field("current_value", want.current_value, current_value);
         compare_field("overflowed", 32'(want.overflowed), 32'(overflowed));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic signed [DATA_W-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [DATA_W-1:0] req_value = '0;
   logic req_first_item = 1'b0;
   logic req_last_item = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic signed [DATA_W-1:0] rsp_partner_value;
   logic signed [DATA_W-1:0] rsp_current_value;
   logic rsp_overflowed;

   two_sum_tracker tracker = new();
   value_request_type request_queue[$];
   logic signed [DATA_W-1:0] array_history[$];
   bit steady_flow = 1'b0;
   bit long_hold_requested = 1'b0;

   two_sum_pair_finder_core #(.SET_CAPACITY(SET_CAPACITY)) DUT (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value(req_value),
      .req_first_item(req_first_item),
      .req_last_item(req_last_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_partner_value(rsp_partner_value),
      .rsp_current_value(rsp_current_value),
      .rsp_overflowed(rsp_overflowed)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int unsigned roll;
      if (steady_flow) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // small values, partners of earlier values, repeats, extremes, full range
   function automatic logic signed [DATA_W-1:0] pick_value(logic signed [DATA_W-1:0] target);
      int unsigned pick;
      int unsigned depth;
      pick = $urandom_range(0, 9);
      depth = array_history.size();
      if (pick < 3) return int'($urandom_range(0, 12)) - 6;
      if (pick < 5 && depth > 0) return target - array_history[$urandom_range(0, depth - 1)];
      if (pick == 5) begin
         case ($urandom_range(0, 4))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return 0;
            3: return -1;
            default: return 1;
         endcase
      end
      if (pick == 6 && depth > 0) return array_history[$urandom_range(0, depth - 1)];
      return $urandom();
   endfunction

   function automatic void queue_request(logic signed [DATA_W-1:0] value, bit first_item,
                                         bit last_item);
      value_request_type r;
      r.value = value;
      r.first_item = first_item;
      r.last_item = last_item;
      request_queue.insert(request_queue.size(), r);
   endfunction

   // broken arrays lose their start or end flag, or restart or end midway
   function automatic void queue_array(logic signed [DATA_W-1:0] target, bit broken);
      value_request_type r;
      int length;
      length = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 40);
      for (int i = 0; i < length; i++) begin
         r.value = pick_value(target);
         r.first_item = (i == 0) ? !(broken && $urandom_range(0, 1))
                                 : (broken && $urandom_range(0, 7) == 0);
         r.last_item = (i == length - 1) ? !(broken && $urandom_range(0, 1))
                                         : (broken && $urandom_range(0, 7) == 0);
         request_queue.insert(request_queue.size(), r);
         if (r.first_item) array_history.delete();
         array_history.insert(array_history.size(), r.value);
      end
   endfunction

   // entered and left at a falling edge
   task automatic drive_requests();
      value_request_type r;
      int gap;
      while (request_queue.size() > 0) begin
         r = request_queue.pop_front();
         gap = pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid <= 1'b1;
         req_value <= r.value;
         req_first_item <= r.first_item;
         req_last_item <= r.last_item;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         tracker.note_value(r.value, r.first_item, r.last_item);
         @(negedge clock);
      end
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (tracker.outstanding() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_target(logic signed [DATA_W-1:0] target);
      csr_write_enable <= 1'b1;
      csr_write_data <= target;
      @(posedge clock);
      tracker.set_target(target);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_random_phase(logic signed [DATA_W-1:0] target, int request_total);
      write_target(target);
      array_history.delete();
      while (request_queue.size() < request_total)
         queue_array(target, $urandom_range(0, 99) < 20);
      drive_requests();
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         tracker.check_outcome(rsp_status, rsp_partner_value, rsp_current_value, rsp_overflowed);
   end

   // response side back-pressure
   initial begin
      int run_length;
      @(negedge clock);
      forever begin
         if (long_hold_requested) begin
            long_hold_requested = 1'b0;
            run_length = LONG_HOLD_CYCLES;
         end else begin
            run_length = pick_gap();
         end
         if (run_length > 0) begin
            rsp_stall <= 1'b1;
            repeat (run_length) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_write_enable || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no handshake for %0d cycles, %0d responses outstanding", $time,
               WATCHDOG_LIMIT, tracker.outstanding());
      $display("** two_sum_pair_finder_core: FAILED **");
      $finish;
   end

   initial begin
      logic signed [DATA_W-1:0] phase_targets[6];
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // target at its reset value of zero
      queue_request(5, 1'b0, 1'b0);
      queue_request(7, 1'b1, 1'b0);
      queue_request(3, 1'b0, 1'b0);
      queue_request(-7, 1'b0, 1'b0);
      queue_request(9, 1'b0, 1'b0);
      queue_request(1, 1'b0, 1'b1);
      queue_request(0, 1'b1, 1'b1);
      queue_request(0, 1'b1, 1'b0);
      queue_request(0, 1'b0, 1'b0);
      queue_request(2, 1'b1, 1'b0);
      queue_request(3, 1'b0, 1'b1);
      queue_request(-2, 1'b0, 1'b0);
      queue_request(VALUE_MIN, 1'b1, 1'b0);
      queue_request(VALUE_MIN, 1'b0, 1'b1);
      queue_request(1, 1'b1, 1'b0);
      queue_request(-1, 1'b0, 1'b1);
      drive_requests();
      wait_drained();

      // difference above the 32-bit range aliases a held value
      write_target(VALUE_MAX);
      queue_request(-1, 1'b1, 1'b0);
      queue_request(VALUE_MIN, 1'b0, 1'b0);
      queue_request(0, 1'b0, 1'b0);
      queue_request(VALUE_MAX, 1'b0, 1'b1);
      drive_requests();
      wait_drained();

      // difference below the 32-bit range
      write_target(VALUE_MIN);
      queue_request(VALUE_MAX, 1'b1, 1'b0);
      queue_request(1, 1'b0, 1'b0);
      queue_request(VALUE_MIN, 1'b0, 1'b0);
      queue_request(0, 1'b0, 1'b1);
      drive_requests();
      wait_drained();

      phase_targets[0] = $urandom();
      phase_targets[1] = -1;
      phase_targets[2] = int'($urandom_range(0, 10)) - 5;
      phase_targets[3] = $urandom();
      phase_targets[4] = VALUE_MAX;
      phase_targets[5] = VALUE_MIN;
      for (int p = 0; p < 6; p++) begin
         if (p == 1) begin
            // full-rate sender against a long response hold-off
            steady_flow = 1'b1;
            long_hold_requested = 1'b1;
         end
         run_random_phase(phase_targets[p], 75);
         steady_flow = 1'b0;
      end

      // fill the set, then dropped inserts, a repeat, a lost partner, a hit
      write_target(0);
      for (int i = 1; i <= SET_CAPACITY; i++) queue_request(i, i == 1, 1'b0);
      queue_request(SET_CAPACITY + 1, 1'b0, 1'b0);
      queue_request(100, 1'b0, 1'b0);
      queue_request(300, 1'b0, 1'b0);
      queue_request(-(SET_CAPACITY + 1), 1'b0, 1'b0);
      queue_request(-100, 1'b0, 1'b0);
      queue_request(5, 1'b0, 1'b1);
      drive_requests();
      wait_drained();

      // overflow flag must stay set across later arrays
      run_random_phase($urandom(), 20);

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d requests under %0d target settings: %0d pairs, %0d arrays ended",
               tracker.request_count, tracker.target_writes + 1, tracker.found_count,
               tracker.end_count);
      $display("without a pair, %0d requests ignored after a pair, overflow flag reached %0d.",
               tracker.ignored_count, tracker.overflow_seen);
      if (tracker.error_count == 0)
         $display("** two_sum_pair_finder_core: PASSED **");
      else
         $display("** two_sum_pair_finder_core: FAILED **");
      $finish;
   end
endmodule
